FILE: hdl/ffsa_pkg.sv
package ffsa_pkg;

  localparam logic [2:0] ST_OK       = 3'd0;
  localparam logic [2:0] ST_NO_FIT   = 3'd1;
  localparam logic [2:0] ST_OVERLAP  = 3'd2;
  localparam logic [2:0] ST_BAD_SIZE = 3'd3;
  localparam logic [2:0] ST_FULL     = 3'd4;

  localparam logic KIND_ALLOC = 1'b0;
  localparam logic KIND_FREE  = 1'b1;

endpackage

FILE: hdl/first_fit_segment_allocator.sv
// First-fit free-segment allocator. The block keeps a table of free
// segments (start, length) sorted by rising start address in a single
// synchronous memory with a registered read port, and serves one request
// word at a time. An allocate word scans from the lowest address and takes
// the first segment at least as long as asked; it either shrinks that
// segment from its front or, when the leftover would be smaller than
// MIN_SEGMENT, removes it. A free word is placed in address order, merges
// with a following segment that it touches, and is checked for overlap
// against both neighbours. Every request yields exactly one result word.
// Timing: a request whose size is rejected goes straight to its result
// word; otherwise the time is set by the memory port and grows with the
// number of segments held. The scan reads one entry per cycle, and every
// entry moved while the table is shifted up or down takes a read state
// (S_SHIFT) and then a write state (S_SWR). A result waits in S_DONE while
// out_ready is low. After reset the table is empty and no clearing pass is
// needed. The user must write the memory_bytes register through
// cfg_we/cfg_data only while idle; the block itself does not enforce this.
module first_fit_segment_allocator
  import ffsa_pkg::*;
#(
  parameter int SEGMENTS     = 32,
  parameter int ADDRESS_BITS = 16,
  parameter int MIN_SEGMENT  = 16
) (
  input  logic                    clk,
  input  logic                    rst,
  input  logic                    cfg_we,
  input  logic [ADDRESS_BITS:0]   cfg_data,
  input  logic                    in_valid,
  output logic                    in_ready,
  input  logic                    kind,
  input  logic [ADDRESS_BITS-1:0] address,
  input  logic [ADDRESS_BITS:0]   length,
  output logic                    out_valid,
  input  logic                    out_ready,
  output logic [2:0]              status,
  output logic [ADDRESS_BITS-1:0] granted_address
);

  localparam int IW = (SEGMENTS > 1) ? $clog2(SEGMENTS) : 1;
  localparam int CW = $clog2(SEGMENTS + 1);
  localparam int AW = ADDRESS_BITS;
  localparam int LW = ADDRESS_BITS + 1;
  localparam int EW = ADDRESS_BITS + 2;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_SCAN  = 3'd1;
  localparam logic [2:0] S_CHECK = 3'd2;
  localparam logic [2:0] S_SHIFT = 3'd3;
  localparam logic [2:0] S_SWR   = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  // Each table entry holds start and length side by side.
  logic [AW+LW-1:0] table_mem [SEGMENTS];
  logic [AW+LW-1:0] rd_data;
  logic             rd_en;
  logic [IW-1:0]    rd_addr;
  logic             wr_en;
  logic [IW-1:0]    wr_addr;
  logic [AW+LW-1:0] wr_data;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      table_mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= table_mem[rd_addr];
    end
  end

  logic [2:0]    state;
  logic [LW-1:0] memory_bytes;
  logic [CW-1:0] count;
  logic [CW-1:0] pos;      // entry being read or found
  logic          rd_pend;  // rd_data holds entry pos-1 from the last read
  logic          req_kind;
  logic [AW-1:0] req_addr;
  logic [LW-1:0] req_len;
  logic [EW-1:0] prev_end; // end of the entry before the one in rd_data
  logic          have_prev;
  logic [CW-1:0] sh_idx;   // shift cursor
  logic          sh_up;
  logic [2:0]    res_status;
  logic [AW-1:0] res_grant;

  logic [AW-1:0] ent_start;
  logic [LW-1:0] ent_len;
  logic [EW-1:0] req_end;
  logic [LW-1:0] rest;
  logic          scan_hit;
  logic          free_prev_ovl;
  logic          free_merge;
  logic          ins_write;

  assign ent_start = rd_data[AW+LW-1:LW];
  assign ent_len   = rd_data[LW-1:0];
  assign req_end   = EW'(req_addr) + EW'(req_len);
  assign rest      = ent_len - req_len;

  // The scan stops at the first entry that fits an allocate, or at the
  // first entry that does not start below the address being freed.
  assign scan_hit = rd_pend && ((req_kind == KIND_ALLOC) ? (ent_len >= req_len)
                                                        : !(ent_start < req_addr));
  assign free_prev_ovl = have_prev && (prev_end > EW'(req_addr));
  assign free_merge    = !free_prev_ovl && (req_end == EW'(ent_start));

  // The final write of an upward shift puts the new segment at pos.
  assign ins_write = (state == S_SWR) && sh_up && (sh_idx == pos);

  assign in_ready        = (state == S_IDLE);
  assign out_valid       = (state == S_DONE);
  assign status          = res_status;
  assign granted_address = res_grant;

  always_comb begin
    rd_en   = 1'b0;
    rd_addr = pos[IW-1:0];
    wr_en   = 1'b0;
    wr_addr = pos[IW-1:0];
    wr_data = '0;
    unique case (state)
      S_SCAN: begin
        // Hold rd_data on a hit so the found entry is still there in S_CHECK.
        rd_en = (pos < count) && !scan_hit;
      end
      S_CHECK: begin
        // Shrink or merge writes the entry at pos.
        if (req_kind == KIND_ALLOC) begin
          wr_en   = (rest >= LW'(MIN_SEGMENT));
          wr_data = {ent_start + req_len[AW-1:0], rest};
        end else begin
          wr_en   = free_merge;
          wr_data = {req_addr, ent_len + req_len};
        end
      end
      S_SHIFT: begin
        rd_en   = sh_up ? (sh_idx != pos) : (sh_idx < count);
        rd_addr = sh_up ? IW'(sh_idx - CW'(1)) : IW'(sh_idx + CW'(1));
      end
      S_SWR: begin
        wr_en   = 1'b1;
        wr_addr = sh_idx[IW-1:0];
        wr_data = ins_write ? {req_addr, req_len} : rd_data;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_IDLE;
      memory_bytes <= {1'b1, {AW{1'b0}}};
      count        <= '0;
    end else begin
      if (cfg_we) begin
        memory_bytes <= cfg_data;
      end
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            req_kind   <= kind;
            req_addr   <= address;
            req_len    <= length;
            pos        <= '0;
            rd_pend    <= 1'b0;
            have_prev  <= 1'b0;
            res_grant  <= '0;
            res_status <= ST_OK;
            if (kind == KIND_ALLOC) begin
              if (length > memory_bytes) begin
                res_status <= ST_BAD_SIZE;
                state      <= S_DONE;
              end else begin
                state <= S_SCAN;
              end
            end else if (length < LW'(MIN_SEGMENT) ||
                         (EW'(address) + EW'(length)) > EW'(memory_bytes)) begin
              res_status <= ST_BAD_SIZE;
              state      <= S_DONE;
            end else begin
              state <= S_SCAN;
            end
          end
        end
        S_SCAN: begin
          // rd_data holds entry pos-1 when rd_pend is set.
          if (scan_hit) begin
            pos   <= pos - CW'(1);
            state <= S_CHECK;
          end else begin
            if (rd_pend) begin
              prev_end  <= EW'(ent_start) + EW'(ent_len);
              have_prev <= 1'b1;
            end
            if (pos < count) begin
              pos <= pos + CW'(1);
            end else if (req_kind == KIND_ALLOC) begin
              res_status <= ST_NO_FIT;
              state      <= S_DONE;
            end else begin
              // Free goes past the last entry.
              if (rd_pend && EW'(ent_start) + EW'(ent_len) > EW'(req_addr)) begin
                res_status <= ST_OVERLAP;
                state      <= S_DONE;
              end else if (!rd_pend && have_prev && prev_end > EW'(req_addr)) begin
                res_status <= ST_OVERLAP;
                state      <= S_DONE;
              end else if (count >= CW'(SEGMENTS)) begin
                res_status <= ST_FULL;
                state      <= S_DONE;
              end else begin
                pos    <= count;
                sh_idx <= count;
                sh_up  <= 1'b1;
                count  <= count + CW'(1);
                state  <= S_SHIFT;
              end
            end
            rd_pend <= (pos < count);
          end
        end
        S_CHECK: begin
          if (req_kind == KIND_ALLOC) begin
            res_grant <= ent_start;
            if (rest >= LW'(MIN_SEGMENT)) begin
              state <= S_DONE;
            end else begin
              sh_idx <= pos;
              sh_up  <= 1'b0;
              count  <= count - CW'(1);
              state  <= S_SHIFT;
            end
          end else if (free_prev_ovl) begin
            res_status <= ST_OVERLAP;
            state      <= S_DONE;
          end else if (req_end > EW'(ent_start)) begin
            res_status <= ST_OVERLAP;
            state      <= S_DONE;
          end else if (req_end == EW'(ent_start)) begin
            state <= S_DONE;  // merged in place by the write above
          end else if (count >= CW'(SEGMENTS)) begin
            res_status <= ST_FULL;
            state      <= S_DONE;
          end else begin
            sh_idx <= count;
            sh_up  <= 1'b1;
            count  <= count + CW'(1);
            state  <= S_SHIFT;
          end
        end
        S_SHIFT: begin
          // Up: move entries pos..count-2 one place up, top first.
          // Down: move entries pos+1..count one place down.
          if (sh_up && sh_idx == pos) begin
            state <= S_SWR;
          end else if (!sh_up && sh_idx >= count) begin
            state <= S_DONE;
          end else begin
            state <= S_SWR;
          end
        end
        S_SWR: begin
          if (sh_up) begin
            if (sh_idx == pos) begin
              state <= S_DONE;
            end else begin
              sh_idx <= sh_idx - CW'(1);
              state  <= S_SHIFT;
            end
          end else begin
            sh_idx <= sh_idx + CW'(1);
            state  <= S_SHIFT;
          end
        end
        S_DONE: begin
          if (out_ready) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (status == ST_OK || granted_address == '0))
    else $error("grant without ok status");

  assert property (@(posedge clk) disable iff (rst)
    count <= CW'(SEGMENTS))
    else $error("segment count beyond table size");

  assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |=> !in_ready)
    else $error("second request taken while one is in flight");

endmodule
